[sv/qfxalu_pkg.sv]
// ----------------------------------------------------------------------------
// qfxalu_pkg
// Shared types and constants of the Q-format fixed-point ALU.
// ----------------------------------------------------------------------------
package qfxalu_pkg;

  localparam int unsigned DataWidth        = 16;
  localparam int unsigned FracWidth        = 4;
  localparam int unsigned CmdWidth         = 4;
  localparam int unsigned MulWidth         = DataWidth + 1;
  localparam int unsigned ProdWidth        = 2 * MulWidth;
  localparam int unsigned DvdWidth         = 2 * DataWidth;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages        = DvdWidth / DivStepsPerStage;

  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);
  localparam int unsigned ResDepth = 16;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam logic [DataWidth-1:0] SatMax = {1'b0, {(DataWidth - 1){1'b1}}};
  localparam logic [DataWidth-1:0] SatMin = {1'b1, {(DataWidth - 1){1'b0}}};

  typedef enum logic [CmdWidth-1:0] {
    CmdAdd    = 4'd0,
    CmdSub    = 4'd1,
    CmdAddSat = 4'd2,
    CmdSubSat = 4'd3,
    CmdMul    = 4'd4,
    CmdDiv    = 4'd5,
    CmdUAdd   = 4'd6,
    CmdUSub   = 4'd7,
    CmdUMul   = 4'd8,
    CmdUDiv   = 4'd9,
    CmdSmooth = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpAddSat,
    OpSubSat,
    OpMul,
    OpDiv,
    OpSmooth,
    OpBad
  } op_e;

  typedef enum logic {
    RegFracBits,
    RegSmoothing
  } cfg_reg_e;

  typedef struct packed {
    op_e                         op;
    logic [DataWidth-1:0]        a;
    logic [DataWidth-1:0]        b;
    logic [FracWidth-1:0]        q;
    logic signed [MulWidth-1:0]  mul_a;
    logic signed [MulWidth-1:0]  mul_b;
    logic [DvdWidth-1:0]         dvd;
    logic [DataWidth-1:0]        dvs;
    logic                        neg;
  } job_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 dz;
    logic                 sat;
    logic                 bad;
  } res_t;

endpackage

[sv/qfxalu_front.sv]
// ----------------------------------------------------------------------------
// qfxalu_front
// Decodes a command and prepares multiplier and divider operands.
// ----------------------------------------------------------------------------
module qfxalu_front import qfxalu_pkg::*; (
  input  logic [CmdWidth-1:0]  command_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  input  logic [FracWidth-1:0] frac_bits_i,
  input  logic [DataWidth-1:0] alpha_i,
  output job_t                 job_o
);

  logic [DataWidth-1:0] mag_a;
  logic [DataWidth-1:0] mag_b;
  logic [DataWidth-1:0] diff;

  assign mag_a = operand_a_i[DataWidth-1] ? -operand_a_i : operand_a_i;
  assign mag_b = operand_b_i[DataWidth-1] ? -operand_b_i : operand_b_i;
  assign diff  = operand_b_i - operand_a_i;

  always_comb begin
    job_o       = '0;
    job_o.a     = operand_a_i;
    job_o.b     = operand_b_i;
    job_o.q     = frac_bits_i;
    unique case (cmd_e'(command_i))
      CmdAdd, CmdUAdd: job_o.op = OpAdd;
      CmdSub, CmdUSub: job_o.op = OpSub;
      CmdAddSat:       job_o.op = OpAddSat;
      CmdSubSat:       job_o.op = OpSubSat;
      CmdMul: begin
        job_o.op    = OpMul;
        job_o.mul_a = {operand_a_i[DataWidth-1], operand_a_i};
        job_o.mul_b = {operand_b_i[DataWidth-1], operand_b_i};
      end
      CmdUMul: begin
        job_o.op    = OpMul;
        job_o.mul_a = {1'b0, operand_a_i};
        job_o.mul_b = {1'b0, operand_b_i};
      end
      CmdDiv: begin
        job_o.op  = OpDiv;
        job_o.dvd = DvdWidth'(mag_a) << frac_bits_i;
        job_o.dvs = mag_b;
        job_o.neg = operand_a_i[DataWidth-1] ^ operand_b_i[DataWidth-1];
      end
      CmdUDiv: begin
        job_o.op  = OpDiv;
        job_o.dvd = DvdWidth'(operand_a_i) << frac_bits_i;
        job_o.dvs = operand_b_i;
      end
      CmdSmooth: begin
        job_o.op    = OpSmooth;
        job_o.mul_a = {1'b0, alpha_i};
        job_o.mul_b = {1'b0, diff};
      end
      default:         job_o.op = OpBad;
    endcase
  end

endmodule

[sv/qfxalu_jobq.sv]
// ----------------------------------------------------------------------------
// qfxalu_jobq
// Small queue of decoded items between the front and the execution pipeline.
// ----------------------------------------------------------------------------
module qfxalu_jobq import qfxalu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  job_t               mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobCntW-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == JobCntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + JobCntW'(do_push) - JobCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/qfxalu_back.sv]
// ----------------------------------------------------------------------------
// qfxalu_back
// Execution pipeline: adder, multiplier and a pipelined restoring divider,
// followed by a result queue with credit-based intake.
// ----------------------------------------------------------------------------
module qfxalu_back import qfxalu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic job_empty_i,
  output logic job_pop_o,
  output res_t res_o,
  output logic empty_o,
  input  logic pop_i
);

  typedef struct packed {
    op_e                         op;
    logic [FracWidth-1:0]        q;
    logic [DataWidth-1:0]        x;
    res_t                        res;
    logic signed [ProdWidth-1:0] prod;
    logic [DataWidth-1:0]        rem;
    logic [DvdWidth-1:0]         dvd;
    logic [DataWidth-1:0]        dvs;
    logic                        neg;
  } stage_t;

  stage_t               stage_q [DivStages];
  stage_t               stage_d [DivStages];
  logic [DivStages-1:0] valid_q;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q;
  logic [ResPtrW-1:0] rd_ptr_q;
  logic [ResCntW-1:0] fill_q, fill_d;
  logic [ResCntW-1:0] credit_q, credit_d;
  logic               do_pop;
  logic               do_write;
  res_t               final_res;

  assign empty_o   = (fill_q == '0);
  assign do_pop    = pop_i && !empty_o;
  assign job_pop_o = !job_empty_i && (credit_q < ResCntW'(ResDepth));
  assign do_write  = valid_q[DivStages-1];
  assign res_o     = mem_q[rd_ptr_q];

  always_comb begin
    stage_t                      src;
    logic [DataWidth:0]          trial;
    logic [DataWidth:0]          sum_ext;
    logic [DataWidth:0]          dif_ext;
    logic signed [ProdWidth-1:0] shifted;
    sum_ext = '0;
    dif_ext = '0;
    shifted = '0;
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        src      = '0;
        src.op   = job_i.op;
        src.q    = job_i.q;
        src.x    = job_i.b;
        src.dvd  = job_i.dvd;
        src.dvs  = job_i.dvs;
        src.neg  = job_i.neg;
        src.prod = $signed(job_i.mul_a) * $signed(job_i.mul_b);
        sum_ext  = {job_i.a[DataWidth-1], job_i.a} + {job_i.b[DataWidth-1], job_i.b};
        dif_ext  = {job_i.a[DataWidth-1], job_i.a} - {job_i.b[DataWidth-1], job_i.b};
        unique case (job_i.op)
          OpAdd: src.res.result = job_i.a + job_i.b;
          OpSub: src.res.result = job_i.a - job_i.b;
          OpAddSat: begin
            src.res.sat    = sum_ext[DataWidth] ^ sum_ext[DataWidth-1];
            src.res.result = !src.res.sat ? sum_ext[DataWidth-1:0] :
                             (sum_ext[DataWidth] ? SatMin : SatMax);
          end
          OpSubSat: begin
            src.res.sat    = dif_ext[DataWidth] ^ dif_ext[DataWidth-1];
            src.res.result = !src.res.sat ? dif_ext[DataWidth-1:0] :
                             (dif_ext[DataWidth] ? SatMin : SatMax);
          end
          OpBad:   src.res.bad = 1'b1;
          default: src.res.result = '0;
        endcase
      end else begin
        src = stage_q[k-1];
      end
      // product scaling one stage after the multiplier
      if (k == 1 && (src.op == OpMul || src.op == OpSmooth)) begin
        shifted        = src.prod >>> src.q;
        src.res.result = (src.op == OpMul) ? shifted[DataWidth-1:0] :
                         src.x - shifted[DataWidth-1:0];
      end
      for (int s = 0; s < DivStepsPerStage; s++) begin
        trial   = {src.rem, src.dvd[DvdWidth-1]};
        src.dvd = {src.dvd[DvdWidth-2:0], 1'b0};
        if (trial >= {1'b0, src.dvs}) begin
          trial      = trial - {1'b0, src.dvs};
          src.dvd[0] = 1'b1;
        end
        src.rem = trial[DataWidth-1:0];
      end
      stage_d[k] = src;
    end
  end

  always_comb begin
    final_res = stage_q[DivStages-1].res;
    if (stage_q[DivStages-1].op == OpDiv) begin
      if (stage_q[DivStages-1].dvs == '0) begin
        final_res.result = '0;
        final_res.dz     = 1'b1;
      end else if (stage_q[DivStages-1].neg) begin
        final_res.result = -stage_q[DivStages-1].dvd[DataWidth-1:0];
      end else begin
        final_res.result = stage_q[DivStages-1].dvd[DataWidth-1:0];
      end
    end
  end

  always_comb begin
    fill_d   = fill_q + ResCntW'(do_write) - ResCntW'(do_pop);
    credit_d = credit_q + ResCntW'(job_pop_o) - ResCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      credit_q <= '0;
    end else begin
      valid_q  <= {valid_q[DivStages-2:0], job_pop_o};
      wr_ptr_q <= do_write ? wr_ptr_q + 1'b1 : wr_ptr_q;
      rd_ptr_q <= do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
      fill_q   <= fill_d;
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      stage_q[k] <= stage_d[k];
    end
    if (do_write) begin
      mem_q[wr_ptr_q] <= final_res;
    end
  end

endmodule

[sv/q_format_fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// q_format_fixed_point_alu
// 16-bit Q-format ALU: wrapping and saturating add/sub, fractional multiply
// and divide, and an unsigned smoothing step.
// ----------------------------------------------------------------------------
// Takes one item per clock while the job queue is not full, and returns one
// result per item, in order. The front decodes each item into a four-entry
// job queue, and the back runs every command through the same eight-stage
// pipeline that is set by the restoring divider (four quotient bits per stage
// over a 32-bit dividend); the multiplier sits in the first stage and the
// product scaling in the second. A sixteen-entry result queue absorbs stalls
// on the pop side. frac_bits (index 0, reset 15) and smoothing_factor
// (index 1, reset 0) are sampled when an item is pushed.
module q_format_fixed_point_alu import qfxalu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [CmdWidth-1:0]  command_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [DataWidth-1:0] result_o,
  output logic                 divide_by_zero_o,
  output logic                 saturated_o,
  output logic                 bad_command_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [DataWidth-1:0] cfg_data_i
);

  logic [FracWidth-1:0] frac_q;
  logic [DataWidth-1:0] alpha_q;
  job_t                 front_job;
  job_t                 head_job;
  logic                 job_empty;
  logic                 job_pop;
  res_t                 res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q  <= FracWidth'(15);
      alpha_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegFracBits:  frac_q  <= cfg_data_i[FracWidth-1:0];
        RegSmoothing: alpha_q <= cfg_data_i;
      endcase
    end
  end

  qfxalu_front u_front (
    .command_i  (command_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .frac_bits_i(frac_q),
    .alpha_i    (alpha_q),
    .job_o      (front_job)
  );

  qfxalu_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_job),
    .full_o (full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (head_job)
  );

  qfxalu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .res_o      (res),
    .empty_o    (empty),
    .pop_i      (pop)
  );

  assign result_o         = res.result;
  assign divide_by_zero_o = res.dz;
  assign saturated_o      = res.sat;
  assign bad_command_o    = res.bad;

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !job_empty)
    else $error("accepted item missing from job queue");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ($countones({divide_by_zero_o, saturated_o, bad_command_o}) <= 1))
    else $error("more than one status flag set");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_command_o) |-> (result_o == '0))
    else $error("bad command with nonzero result");

endmodule
